// ----- src/assert_macros.svh -----
// assertion macros shared by the scheduler rtl
// each macro assumes a clock named clk and an active-low reset named rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/tods_pkg.sv -----
// types, codes and constants of the time-of-day setpoint scheduler
// no dependencies
package tods_pkg;

  localparam logic [1:0] OP_STEP  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [23:0] MS_PER_MIN = 24'd60000;
  localparam logic [23:0] TIMER_MAX  = 24'hFFFFFF;
  localparam logic signed [11:0] RAMP_STEP = 12'sd5;

  typedef logic signed [10:0] temp_t;

  typedef struct packed {
    logic [4:0] hr;
    logic [5:0] mn;
    temp_t      heat;
    temp_t      cool;
    logic [7:0] ramp;
  } entry_t;

  function automatic temp_t ramp_toward(input temp_t now, input temp_t target);
    logic signed [11:0] t;
    temp_t              res;
    res = now;
    if (target > now) begin
      t = 12'(now) + RAMP_STEP;
      res = (t > 12'(target)) ? target : t[10:0];
    end else if (target < now) begin
      t = 12'(now) - RAMP_STEP;
      res = (t < 12'(target)) ? target : t[10:0];
    end
    return res;
  endfunction

endpackage

// ----- src/tods_cmp.sv -----
// shared interval comparator of the scheduler
// depends on tods_pkg for the entry type
module tods_cmp (
  input  logic               [4:0] hour,
  input  logic               [5:0] minute,
  input  tods_pkg::entry_t         a,
  input  tods_pkg::entry_t         b,
  input  logic                     wrap,
  output logic                     match
);

  logic after_a;
  logic before_b;
  logic mid;

  always_comb begin
    after_a  = (hour == a.hr) && (minute >= a.mn);
    before_b = (hour == b.hr) && (minute < b.mn);
    if (wrap) begin
      mid = (hour > a.hr) || (hour < b.hr);
    end else begin
      mid = (hour > a.hr) && (hour < b.hr);
    end
    match = after_a || mid || before_b;
  end

endmodule

// ----- src/tods_table.sv -----
// schedule entry memory, one write port and one registered read port
// depends on tods_pkg for the entry type
module tods_table #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic             [AW-1:0] wr_addr,
  input  tods_pkg::entry_t          wr_data,
  input  logic                      rd_en,
  input  logic             [AW-1:0] rd_addr,
  output tods_pkg::entry_t          rd_data
);

  tods_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/time_of_day_setpoint_scheduler.sv -----
// top level of the time-of-day setpoint scheduler: sequencer, setpoint and timer state
// depends on tods_pkg, tods_cmp, tods_table and assert_macros.svh
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | operation, time, elapsed, entry fields
//  out_    | output    | out_valid/out_ready | program, setpoints, ramp flag
//  cfg_    | input     | cfg_valid/cfg_ready | entry count
//
// step and start requests go from start through step, wrap and fetch to done; the step state walks
// the n entries in use over the entry memory through the one interval comparator
// load requests and unused codes go straight to done; in_ready rises with out_valid
// in_ready is high only while the sequencer is idle; cfg_ready is always high
// a full output register holds the sequencer in its last state until out_ready
// rst_n is synchronous; the entry memory is not cleared
module time_of_day_setpoint_scheduler #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [1:0]  in_operation,
  input  logic        [4:0]  in_hour,
  input  logic        [5:0]  in_minute,
  input  logic        [15:0] in_elapsed_ms,
  input  logic        [2:0]  in_entry_index,
  input  logic        [4:0]  in_entry_hour,
  input  logic        [5:0]  in_entry_minute,
  input  logic signed [10:0] in_entry_heating,
  input  logic signed [10:0] in_entry_cooling,
  input  logic        [7:0]  in_entry_ramp_minutes,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [3:0]  out_active_program,
  output logic signed [10:0] out_heating_setpoint,
  output logic signed [10:0] out_cooling_setpoint,
  output logic               out_ramp_step_taken,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [3:0]  cfg_data
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int PW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_WRAP  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic             [2:0]  state_r;
  logic             [1:0]  op_r;
  logic             [4:0]  hr_r;
  logic             [5:0]  mn_r;
  logic             [AW-1:0] cnt_r;
  tods_pkg::entry_t        prev_r;
  tods_pkg::entry_t        first_r;
  logic             [PW-1:0] prog_r;
  tods_pkg::temp_t         heat_r;
  tods_pkg::temp_t         cool_r;
  logic             [23:0] timer_r;
  logic             [23:0] prod_r;
  logic             [3:0]  ecount_r;
  logic                    out_valid_r;
  logic             [3:0]  out_prog_r;
  tods_pkg::temp_t         out_heat_r;
  tods_pkg::temp_t         out_cool_r;
  logic                    out_step_r;

  logic             [PW-1:0] n_use;
  logic             [PW-1:0] last_idx;
  logic             [PW-1:0] prog_wrap;
  logic             [PW-1:0] prog_fix;
  logic                    in_acc;
  logic                    wr_en;
  tods_pkg::entry_t        wr_data;
  logic                    rd_en;
  logic             [AW-1:0] rd_addr;
  tods_pkg::entry_t        rd_data;
  tods_pkg::entry_t        cmp_b;
  logic                    cmp_wrap;
  logic                    cmp_match;
  logic             [24:0] timer_sum;
  logic             [23:0] timer_sat;
  logic                    out_free;
  logic                    fire_step;
  tods_pkg::temp_t         heat_nxt;
  tods_pkg::temp_t         cool_nxt;
  logic                    walk_last;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_active_program   = out_prog_r;
  assign out_heating_setpoint = out_heat_r;
  assign out_cooling_setpoint = out_cool_r;
  assign out_ramp_step_taken  = out_step_r;

  always_comb begin
    if (ecount_r == 4'd0) begin
      n_use = PW'(1);
    end else if (32'(ecount_r) > MAX_ENTRIES) begin
      n_use = PW'(MAX_ENTRIES);
    end else begin
      n_use = PW'(ecount_r);
    end
  end

  assign last_idx  = n_use - 1'b1;
  assign walk_last = (PW'(cnt_r) == last_idx);

  assign cmp_wrap = (state_r == S_WRAP);
  assign cmp_b    = cmp_wrap ? first_r : rd_data;

  tods_cmp u_cmp (
    .hour   (hr_r),
    .minute (mn_r),
    .a      (prev_r),
    .b      (cmp_b),
    .wrap   (cmp_wrap),
    .match  (cmp_match)
  );

  assign prog_wrap = cmp_match ? n_use : prog_r;
  assign prog_fix  = ((prog_wrap == '0) || (prog_wrap > n_use)) ? n_use : prog_wrap;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_r)
      S_START: begin
        rd_en = 1'b1;
      end
      S_STEP: begin
        rd_en   = !walk_last;
        rd_addr = cnt_r + 1'b1;
      end
      S_WRAP: begin
        rd_en   = 1'b1;
        rd_addr = AW'(prog_fix - 1'b1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en = in_acc && (in_operation == tods_pkg::OP_LOAD) &&
                 (32'(in_entry_index) < MAX_ENTRIES);

  always_comb begin
    wr_data.hr   = in_entry_hour;
    wr_data.mn   = in_entry_minute;
    wr_data.heat = in_entry_heating;
    wr_data.cool = in_entry_cooling;
    wr_data.ramp = in_entry_ramp_minutes;
  end

  tods_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign timer_sum = {1'b0, timer_r} + 25'(in_elapsed_ms);
  assign timer_sat = timer_sum[24] ? tods_pkg::TIMER_MAX : timer_sum[23:0];

  assign fire_step = (op_r == tods_pkg::OP_STEP) && (timer_r > prod_r);

  always_comb begin
    unique case (op_r)
      tods_pkg::OP_STEP: begin
        heat_nxt = fire_step ? tods_pkg::ramp_toward(heat_r, rd_data.heat) : heat_r;
        cool_nxt = fire_step ? tods_pkg::ramp_toward(cool_r, rd_data.cool) : cool_r;
      end
      tods_pkg::OP_START: begin
        heat_nxt = rd_data.heat;
        cool_nxt = rd_data.cool;
      end
      default: begin
        heat_nxt = heat_r;
        cool_nxt = cool_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      prog_r      <= PW'(1);
      heat_r      <= '0;
      cool_r      <= '0;
      timer_r     <= '0;
      ecount_r    <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ecount_r <= cfg_data;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            timer_r <= timer_sat;
            cnt_r   <= '0;
            if ((in_operation == tods_pkg::OP_STEP) ||
                (in_operation == tods_pkg::OP_START)) begin
              state_r <= S_START;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_START: begin
          state_r <= S_STEP;
        end
        S_STEP: begin
          if ((cnt_r != '0) && cmp_match) begin
            prog_r <= PW'(cnt_r);
          end
          if (walk_last) begin
            state_r <= S_WRAP;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_WRAP: begin
          prog_r  <= prog_fix;
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            heat_r <= heat_nxt;
            cool_r <= cool_nxt;
            if (fire_step) begin
              timer_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_operation;
      hr_r <= in_hour;
      mn_r <= in_minute;
    end
    if (state_r == S_STEP) begin
      prev_r <= rd_data;
      if (cnt_r == '0) begin
        first_r <= rd_data;
      end
    end
    if (state_r == S_FETCH) begin
      prod_r <= 24'(rd_data.ramp) * tods_pkg::MS_PER_MIN;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_prog_r <= 4'(prog_r);
      out_heat_r <= heat_nxt;
      out_cool_r <= cool_nxt;
      out_step_r <= fire_step;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, in_acc, state_r != S_IDLE)
  `ASSERT_IMPL(a_walk_in_range, state_r == S_STEP, PW'(cnt_r) < n_use)
  `ASSERT_IMPL(a_prog_in_range, state_r == S_FETCH, (prog_r != '0) && (prog_r <= n_use))
  `ASSERT_NEXT(a_hold_when_full, (state_r == S_DONE) && out_valid_r && !out_ready, state_r == S_DONE)

endmodule

// ----- tb/tods_checker.sv -----
`timescale 1ns / 1ps
// result checker for the time-of-day setpoint scheduler: follows the request,
// result and entry-count channels, predicts every result and compares it
// depends on tods_pkg
module tods_checker #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [1:0]  in_operation,
  input  logic        [4:0]  in_hour,
  input  logic        [5:0]  in_minute,
  input  logic        [15:0] in_elapsed_ms,
  input  logic        [2:0]  in_entry_index,
  input  logic        [4:0]  in_entry_hour,
  input  logic        [5:0]  in_entry_minute,
  input  logic signed [10:0] in_entry_heating,
  input  logic signed [10:0] in_entry_cooling,
  input  logic        [7:0]  in_entry_ramp_minutes,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [3:0]  out_active_program,
  input  logic signed [10:0] out_heating_setpoint,
  input  logic signed [10:0] out_cooling_setpoint,
  input  logic               out_ramp_step_taken,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic        [3:0]  cfg_data,
  output int                 failures,
  output int                 pending
);

  localparam int MS_PER_MINUTE = 60000;
  localparam int TIMER_CEILING = 16777215;
  localparam int RAMP_TENTHS   = 5;

  typedef struct packed {
    logic [3:0]      prog;
    tods_pkg::temp_t heat;
    tods_pkg::temp_t cool;
    logic            stepped;
  } setpoint_result_t;

  tods_pkg::entry_t schedule [MAX_ENTRIES];
  logic [3:0]       entry_count_reg;
  int               cur_prog;
  tods_pkg::temp_t  heat_now;
  tods_pkg::temp_t  cool_now;
  int               ramp_ms;
  setpoint_result_t expected_setpoints [$];
  int               mismatch_count = 0;
  int               pending_count = 0;

  assign failures = mismatch_count;
  assign pending  = pending_count;

  function automatic tods_pkg::temp_t step_toward(input tods_pkg::temp_t now,
                                                  input tods_pkg::temp_t target);
    int n;
    n = int'(now);
    if (target > now) begin
      n = n + RAMP_TENTHS;
      if (n > target) n = int'(target);
    end else if (target < now) begin
      n = n - RAMP_TENTHS;
      if (n < target) n = int'(target);
    end
    return tods_pkg::temp_t'(n);
  endfunction

  // last match wins; the final entry also covers the wrap past midnight
  function automatic void pick_entry(input int h, input int m);
    int               n;
    tods_pkg::entry_t a;
    tods_pkg::entry_t b;
    n = int'(entry_count_reg);
    if (n < 1) n = 1;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    for (int y = 0; y < n - 1; y++) begin
      a = schedule[y];
      b = schedule[y + 1];
      if ((h == a.hr && m >= a.mn) || (h > a.hr && h < b.hr) || (h == b.hr && m < b.mn))
        cur_prog = y + 1;
    end
    a = schedule[n - 1];
    b = schedule[0];
    if ((h == a.hr && m >= a.mn) || h > a.hr || h < b.hr || (h == b.hr && m < b.mn))
      cur_prog = n;
    if (cur_prog < 1 || cur_prog > n) cur_prog = n;
  endfunction

  function automatic setpoint_result_t next_setpoints(input logic [1:0] op, input int h,
                                                      input int m, input int el,
                                                      input logic [2:0] idx,
                                                      input tods_pkg::entry_t loaded);
    tods_pkg::entry_t e;
    setpoint_result_t r;
    r.stepped = 1'b0;
    ramp_ms = ramp_ms + el;
    if (ramp_ms > TIMER_CEILING) ramp_ms = TIMER_CEILING;
    if (op == tods_pkg::OP_LOAD) begin
      if (idx < MAX_ENTRIES) schedule[idx] = loaded;
    end else if (op == tods_pkg::OP_STEP || op == tods_pkg::OP_START) begin
      pick_entry(h, m);
      e = schedule[cur_prog - 1];
      if (op == tods_pkg::OP_START) begin
        heat_now = e.heat;
        cool_now = e.cool;
      end else if (ramp_ms > int'(e.ramp) * MS_PER_MINUTE) begin
        cool_now  = step_toward(cool_now, e.cool);
        heat_now  = step_toward(heat_now, e.heat);
        ramp_ms   = 0;
        r.stepped = 1'b1;
      end
    end
    r.prog = 4'(cur_prog);
    r.heat = heat_now;
    r.cool = cool_now;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    setpoint_result_t got;
    setpoint_result_t want;
    tods_pkg::entry_t loaded;
    if (!rst_n) begin
      entry_count_reg = 4'd1;
      cur_prog        = 1;
      heat_now        = '0;
      cool_now        = '0;
      ramp_ms         = 0;
      expected_setpoints.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.prog    = out_active_program;
        got.heat    = out_heating_setpoint;
        got.cool    = out_cooling_setpoint;
        got.stepped = out_ramp_step_taken;
        if (expected_setpoints.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t ns: unexpected result: prog %0d heat %0d cool %0d step %0b",
                     $time, got.prog, got.heat, got.cool, got.stepped);
          mismatch_count++;
        end else begin
          want = expected_setpoints.pop_front();
          if (got.prog !== want.prog || got.heat !== want.heat ||
              got.cool !== want.cool || got.stepped !== want.stepped) begin
            if (mismatch_count < 10)
              $display("%0t ns: want prog %0d heat %0d cool %0d step %0b, got %0d %0d %0d %0b",
                       $time, want.prog, want.heat, want.cool, want.stepped,
                       got.prog, got.heat, got.cool, got.stepped);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) entry_count_reg = cfg_data;
      if (in_valid && in_ready) begin
        loaded.hr   = in_entry_hour;
        loaded.mn   = in_entry_minute;
        loaded.heat = in_entry_heating;
        loaded.cool = in_entry_cooling;
        loaded.ramp = in_entry_ramp_minutes;
        expected_setpoints.push_back(next_setpoints(in_operation, int'(in_hour),
                                                    int'(in_minute), int'(in_elapsed_ms),
                                                    in_entry_index, loaded));
      end
    end
    pending_count = expected_setpoints.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// top of the scheduler testbench: clock, reset, request and entry-count stimulus
// depends on tods_pkg, time_of_day_setpoint_scheduler and tods_checker
module tb;

  localparam logic [1:0]  OP_UNUSED         = 2'd3;
  localparam int          EPOCHS            = 4;
  localparam int          EPOCH_REQUESTS    = 80;
  localparam int          HOLD_CYCLES       = 300;
  localparam int          SATURATE_REQUESTS = 260;
  localparam logic [15:0] EXTREME_COUNTS    = {4'd15, 4'd0, 4'd8, 4'd1};

  typedef struct packed {
    logic [1:0]      op;
    logic [4:0]      hr;
    logic [5:0]      mn;
    logic [15:0]     el;
    logic [2:0]      idx;
    logic [4:0]      ehr;
    logic [5:0]      emn;
    tods_pkg::temp_t eheat;
    tods_pkg::temp_t ecool;
    logic [7:0]      eramp;
  } sched_request_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      in_operation = '0;
  logic [4:0]      in_hour = '0;
  logic [5:0]      in_minute = '0;
  logic [15:0]     in_elapsed_ms = '0;
  logic [2:0]      in_entry_index = '0;
  logic [4:0]      in_entry_hour = '0;
  logic [5:0]      in_entry_minute = '0;
  tods_pkg::temp_t in_entry_heating = '0;
  tods_pkg::temp_t in_entry_cooling = '0;
  logic [7:0]      in_entry_ramp_minutes = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [3:0]      out_active_program;
  tods_pkg::temp_t out_heating_setpoint;
  tods_pkg::temp_t out_cooling_setpoint;
  logic            out_ramp_step_taken;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [3:0]      cfg_data = '0;
  int              failures;
  int              pending;

  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_left = 0;
  int              n_step = 0;
  int              n_start = 0;
  int              n_load = 0;
  int              n_other = 0;
  int              cfg_writes = 0;
  logic [4:0]      loaded_hr [8];
  logic [5:0]      loaded_mn [8];

  time_of_day_setpoint_scheduler uut (.*);
  tods_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side; a long hold-off is counted down here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("time_of_day_setpoint_scheduler regression: fail");
    $finish;
  end

  function automatic tods_pkg::temp_t random_temp();
    return tods_pkg::temp_t'(int'($urandom_range(0, 1400)) - 400);
  endfunction

  function automatic sched_request_t random_fields();
    sched_request_t r;
    r.op    = tods_pkg::OP_STEP;
    r.hr    = 5'($urandom_range(0, 23));
    r.mn    = 6'($urandom_range(0, 59));
    r.el    = 16'($urandom);
    r.idx   = 3'($urandom);
    r.ehr   = 5'($urandom_range(0, 23));
    r.emn   = 6'($urandom_range(0, 59));
    r.eheat = random_temp();
    r.ecool = random_temp();
    r.eramp = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic sched_request_t load_req(input int idx, input int h, input int m,
                                              input int heat, input int cool,
                                              input int ramp);
    sched_request_t r;
    r       = random_fields();
    r.op    = tods_pkg::OP_LOAD;
    r.el    = '0;
    r.idx   = 3'(idx);
    r.ehr   = 5'(h);
    r.emn   = 6'(m);
    r.eheat = tods_pkg::temp_t'(heat);
    r.ecool = tods_pkg::temp_t'(cool);
    r.eramp = 8'(ramp);
    return r;
  endfunction

  function automatic sched_request_t time_req(input logic [1:0] op, input int h,
                                              input int m, input int el);
    sched_request_t r;
    r    = random_fields();
    r.op = op;
    r.hr = 5'(h);
    r.mn = 6'(m);
    r.el = 16'(el);
    return r;
  endfunction

  // times near a loaded start hit the same-hour boundaries
  function automatic sched_request_t random_request();
    sched_request_t r;
    int             pick;
    int             k;
    int             m;
    r    = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 50) r.op = tods_pkg::OP_STEP;
    else if (pick < 70) r.op = tods_pkg::OP_START;
    else if (pick < 95) r.op = tods_pkg::OP_LOAD;
    else r.op = OP_UNUSED;
    case ($urandom_range(0, 3))
      0: r.el = '0;
      1: r.el = 16'hFFFF;
      2: r.el = 16'($urandom_range(0, 200));
      default: ;
    endcase
    if (r.op != tods_pkg::OP_LOAD && $urandom_range(0, 2) == 0) begin
      k    = $urandom_range(0, 7);
      m    = int'(loaded_mn[k]) + int'($urandom_range(0, 2)) - 1;
      r.hr = loaded_hr[k];
      r.mn = 6'((m < 0) ? 0 : (m > 59) ? 59 : m);
    end
    return r;
  endfunction

  task automatic send_request(input sched_request_t r);
    in_valid              <= 1'b1;
    in_operation          <= r.op;
    in_hour               <= r.hr;
    in_minute             <= r.mn;
    in_elapsed_ms         <= r.el;
    in_entry_index        <= r.idx;
    in_entry_hour         <= r.ehr;
    in_entry_minute       <= r.emn;
    in_entry_heating      <= r.eheat;
    in_entry_cooling      <= r.ecool;
    in_entry_ramp_minutes <= r.eramp;
    do @(posedge clk); while (!in_ready);
    case (r.op)
      tods_pkg::OP_STEP:  n_step++;
      tods_pkg::OP_START: n_start++;
      tods_pkg::OP_LOAD: begin
        n_load++;
        loaded_hr[r.idx] = r.ehr;
        loaded_mn[r.idx] = r.emn;
      end
      default:  n_other++;
    endcase
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [3:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // well-formed table: starts ascending through the day
  task automatic load_sorted_schedule(input int ramp_lo, input int ramp_hi);
    sched_request_t r;
    int             t;
    for (int k = 0; k < 8; k++) begin
      t       = k * 180 + $urandom_range(0, 179);
      r       = random_fields();
      r.op    = tods_pkg::OP_LOAD;
      r.idx   = 3'(k);
      r.ehr   = 5'(t / 60);
      r.emn   = 6'(t % 60);
      r.eramp = 8'($urandom_range(ramp_lo, ramp_hi));
      send_request(r);
    end
  endtask

  initial begin : stimulus
    sched_request_t r;
    for (int k = 0; k < 8; k++) begin
      loaded_hr[k] = '0;
      loaded_mn[k] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 76;
    write_entry_count(4'd8);
    send_request(load_req(0, 0, 30, 180, 240, 0));
    send_request(load_req(1, 6, 30, -400, 1000, 1));
    send_request(load_req(2, 8, 15, 1000, -400, 255));
    send_request(load_req(3, 11, 59, 200, 260, 2));
    send_request(load_req(4, 14, 0, 205, 255, 0));
    send_request(load_req(5, 17, 45, 190, 250, 1));
    send_request(load_req(6, 21, 0, 160, 280, 3));
    send_request(load_req(7, 23, 59, 150, 300, 0));
    // before the first start of the day: wraps to the last entry
    send_request(time_req(tods_pkg::OP_START, 0, 10, 0));
    send_request(time_req(tods_pkg::OP_STEP, 0, 30, 16'hFFFF));
    send_request(time_req(tods_pkg::OP_STEP, 7, 0, 16'hFFFF));
    send_request(time_req(tods_pkg::OP_STEP, 8, 14, 0));
    send_request(time_req(tods_pkg::OP_STEP, 8, 15, 16'hFFFF));
    send_request(time_req(OP_UNUSED, 12, 0, 16'hFFFF));
    send_request(time_req(tods_pkg::OP_START, 12, 0, 0));
    send_request(time_req(tods_pkg::OP_START, 14, 0, 0));
    // ramp step with setpoints already on target
    send_request(time_req(tods_pkg::OP_STEP, 14, 30, 5));
    send_request(time_req(tods_pkg::OP_STEP, 21, 30, 16'hFFFF));
    send_request(time_req(tods_pkg::OP_STEP, 23, 0, 16'hFFFF));
    send_request(time_req(tods_pkg::OP_STEP, 23, 59, 16'hFFFF));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 23 : 0;
      for (int epoch = 0; epoch < EPOCHS; epoch++) begin
        if (phase == 0) write_entry_count(EXTREME_COUNTS[epoch * 4 +: 4]);
        else write_entry_count(4'($urandom_range(0, 15)));
        if ($urandom_range(0, 1) == 1) load_sorted_schedule(0, 3);
        if (phase == 2 && epoch == 1) hold_left = HOLD_CYCLES;
        repeat (EPOCH_REQUESTS) send_request(random_request());
      end
    end

    // long ramp periods and full elapsed steps drive the timer into saturation
    write_entry_count(4'd8);
    load_sorted_schedule(255, 255);
    repeat (SATURATE_REQUESTS) begin
      r    = random_fields();
      r.op = ($urandom_range(0, 3) == 0) ? OP_UNUSED : tods_pkg::OP_START;
      r.el = 16'hFFFF;
      send_request(r);
    end
    repeat (6) begin
      r    = random_fields();
      r.op = tods_pkg::OP_STEP;
      send_request(r);
    end

    wait_idle();
    $display("covered %0d step, %0d start, %0d load and %0d unused-code requests",
             n_step, n_start, n_load, n_other);
    $display("across %0d entry-count writes, a timer saturation run and a %0d-cycle stall",
             cfg_writes, HOLD_CYCLES);
    if (failures == 0 && pending == 0) begin
      $display("time_of_day_setpoint_scheduler regression: pass");
    end else begin
      $display("time_of_day_setpoint_scheduler regression: fail");
    end
    $finish;
  end

endmodule

// ----- time_of_day_setpoint_scheduler.f -----
+incdir+src
src/tods_pkg.sv
src/tods_cmp.sv
src/tods_table.sv
src/time_of_day_setpoint_scheduler.sv
tb/tods_checker.sv
tb/tb.sv
